/* rtl/core/water_ripple_stencil_top_defines.svh */
// Assertion macros used by the verification checker of the ripple block.
`ifndef WATER_RIPPLE_STENCIL_TOP_DEFINES_SVH
`define WATER_RIPPLE_STENCIL_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define WRS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("water ripple check failed");

// Next-cycle implication, switched off while reset is high.
`define WRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("water ripple check failed");

`endif

/* rtl/core/wrs_pkg.sv */
`default_nettype none

package wrs_pkg;

  // Pixel packing: three 8-bit channels.
  localparam int PIX_W  = 24;
  localparam int CH_W   = 8;
  localparam int NUM_CH = 3;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int DIM_W      = 9;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 2'd0,
    CFG_WIDTH  = 2'd1,
    CFG_HEIGHT = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

/* rtl/core/water_ripple_stencil_top.sv */
// Water ripple stencil over a raster-order RGB pixel stream.
// Input channel: in_valid/in_stall with kind, pixel_in, frame_start and skip_frame.
// A pixel word (kind 0) of row y releases the result of the pixel above it, so results
// trail the input by one row; drain words (kind 1) release the last row of a frame.
// Output channel: out_valid/out_stall with pixel_out and frame_end.
// Configuration: cfg_valid/cfg_ready write enable, frame_width or frame_height; a new
// value takes effect at the next frame start.
// A result released by an accepted word passes the frame store read, then the output
// register. Throughput is one word per cycle while in_stall is low; the row buffer does
// one write and reads both neighbors, the frame store one read and one write, per cycle.
// While the receiver stalls, the words in flight hold and in_stall rises as soon as
// the result stage is full.
// Reset clears the frame store with a sweep over all MAX_WIDTH*MAX_HEIGHT entries, during
// which in_stall is high. The same sweep runs when a filtered frame starts with a
// size other than the one the store holds; it begins once the result stage is empty.
`default_nettype none

module water_ripple_stencil_top #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           kind,
  input  logic [wrs_pkg::PIX_W-1:0]      pixel_in,
  input  logic                           frame_start,
  input  logic                           skip_frame,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [wrs_pkg::PIX_W-1:0]      pixel_out,
  output logic                           frame_end,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [wrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wrs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wrs_pkg::*;

  localparam int XB    = $clog2(MAX_WIDTH);
  localparam int WB    = $clog2(MAX_WIDTH + 1);
  localparam int YB    = $clog2(MAX_HEIGHT);
  localparam int HB    = $clog2(MAX_HEIGHT + 1);
  localparam int RD    = 2 * MAX_WIDTH;
  localparam int RA    = $clog2(RD);
  localparam int FD    = MAX_WIDTH * MAX_HEIGHT;
  localparam int FA    = $clog2(FD);
  localparam int RST_W = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int RST_H = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

  // Words carried from the read stage to the result stage.
  typedef struct packed {
    logic             x0;
    logic             has_left;
    logic             has_right;
    logic             has_above;
    logic             has_below;
    logic             bypass;
    logic             f_end;
    logic [FA-1:0]    fa;
    logic [PIX_W-1:0] first;
    logic [PIX_W-1:0] below;
  } s1_t;

  // Configuration registers.
  logic             enable;
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;

  // Frame state.
  logic [WB-1:0]    act_w;
  logic [HB-1:0]    act_h;
  logic             bypass;
  logic [XB-1:0]    col;
  logic [YB-1:0]    row;
  logic             all_rcv;
  logic [WB-1:0]    flush_col;
  logic [WB-1:0]    st_w;
  logic [HB-1:0]    st_h;
  logic [PIX_W-1:0] first_cur;

  // Frame store clearing sweep.
  logic             clr_active;
  logic [FA-1:0]    clr_addr;

  // Memories and their registered read data.
  logic [PIX_W-1:0] rmem [RD];
  logic [PIX_W-1:0] fmem [FD];
  logic [PIX_W-1:0] rd_right;
  logic [PIX_W-1:0] rd_above;
  logic [PIX_W-1:0] fs_rd;

  // Result stage.
  logic             s1_valid;
  s1_t              s1;
  s1_t              s1_next;
  logic [PIX_W-1:0] cen_reg;
  logic [PIX_W-1:0] left_reg;

  // Stage-0 decode.
  logic [WB-1:0]    sat_w;
  logic [HB-1:0]    sat_h;
  logic             begins;
  logic             filt_new;
  logic             need_clear;
  logic             advance;
  logic             accept;
  logic [WB-1:0]    cur_w;
  logic [HB-1:0]    cur_h;
  logic [XB-1:0]    px;
  logic [YB-1:0]    py;
  logic             emit;
  logic [XB-1:0]    ex;
  logic [YB-1:0]    ey;
  logic             has_right;
  logic [XB-1:0]    rx;
  logic [RA-1:0]    ra_right;
  logic [RA-1:0]    ra_above;
  logic [RA-1:0]    wa;
  logic [FA-1:0]    fa;

  // Stage-1 datapath.
  logic [PIX_W-1:0] centre;
  logic [PIX_W-1:0] filt;
  logic [PIX_W-1:0] res;
  logic [2:0]       ncnt;
  logic [9:0]       sum;
  logic [8:0]       half;
  logic [CH_W-1:0]  prev;

  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      enable       <= 1'b1;
      frame_width  <= DIM_W'(256);
      frame_height <= DIM_W'(256);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLE: enable       <= cfg_data[0];
        CFG_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        CFG_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame size as latched at a frame start.
  always_comb begin
    if (frame_width < DIM_W'(2)) begin
      sat_w = WB'(2);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      sat_w = WB'(MAX_WIDTH);
    end else begin
      sat_w = WB'(frame_width);
    end
    if (frame_height < DIM_W'(2)) begin
      sat_h = HB'(2);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      sat_h = HB'(MAX_HEIGHT);
    end else begin
      sat_h = HB'(frame_height);
    end
  end

  // Input handshake and position decode.
  always_comb begin
    begins     = !kind && (frame_start || all_rcv);
    filt_new   = enable && !skip_frame;
    need_clear = in_valid && begins && filt_new && ((sat_w != st_w) || (sat_h != st_h));
    advance    = !out_valid || !out_stall;
    in_stall   = clr_active || (s1_valid && !advance) || need_clear;
    accept     = in_valid && !in_stall;
    cur_w      = begins ? sat_w : act_w;
    cur_h      = begins ? sat_h : act_h;
    px         = begins ? '0 : col;
    py         = begins ? '0 : row;
    if (kind) begin
      emit = all_rcv && (flush_col < act_w);
      ex   = flush_col[XB-1:0];
      ey   = YB'(act_h - HB'(1));
    end else begin
      emit = !begins && (row != '0);
      ex   = px;
      ey   = YB'(py - YB'(1));
    end
    has_right = (WB'(ex) + WB'(1)) < act_w;
    rx        = has_right ? XB'(ex + XB'(1)) : ex;
    ra_right  = (ey[0] ? RA'(MAX_WIDTH) : RA'(0)) + RA'(rx);
    ra_above  = (ey[0] ? RA'(0) : RA'(MAX_WIDTH)) + RA'(ex);
    wa        = (py[0] ? RA'(MAX_WIDTH) : RA'(0)) + RA'(px);
    fa        = FA'(ey) * FA'(MAX_WIDTH) + FA'(ex);
  end

  // Payload for the result stage.
  always_comb begin
    s1_next.x0        = (ex == '0);
    s1_next.has_left  = (ex != '0);
    s1_next.has_right = has_right;
    s1_next.has_above = (ey != '0);
    s1_next.has_below = !kind;
    s1_next.bypass    = bypass;
    s1_next.f_end     = ((WB'(ex) + WB'(1)) == act_w) && ((HB'(ey) + HB'(1)) == act_h);
    s1_next.fa        = fa;
    s1_next.first     = first_cur;
    s1_next.below     = pixel_in;
  end

  // Position counters and frame settings.
  always_ff @(posedge clk) begin
    if (rst) begin
      act_w     <= WB'(RST_W);
      act_h     <= HB'(RST_H);
      bypass    <= 1'b0;
      col       <= '0;
      row       <= '0;
      all_rcv   <= 1'b1;
      flush_col <= WB'(RST_W);
    end else if (accept) begin
      if (kind) begin
        if (emit) begin
          flush_col <= flush_col + WB'(1);
        end
      end else begin
        if (begins) begin
          act_w     <= sat_w;
          act_h     <= sat_h;
          bypass    <= !filt_new;
          all_rcv   <= 1'b0;
          flush_col <= '0;
        end
        if ((WB'(px) + WB'(1)) >= cur_w) begin
          col <= '0;
          if ((HB'(py) + HB'(1)) >= cur_h) begin
            row       <= '0;
            all_rcv   <= 1'b1;
            flush_col <= '0;
          end else begin
            row <= YB'(py + YB'(1));
          end
        end else begin
          col <= XB'(px + XB'(1));
          row <= py;
        end
      end
    end
  end

  // First pixel of the row being received.
  always_ff @(posedge clk) begin
    if (accept && !kind && (px == '0)) begin
      first_cur <= pixel_in;
    end
  end

  // Row buffer: write the arriving pixel, read right and upper neighbors.
  always_ff @(posedge clk) begin
    if (accept && !kind) begin
      rmem[wa] <= pixel_in;
    end
    if (accept && emit) begin
      rd_right <= rmem[ra_right];
      rd_above <= rmem[ra_above];
    end
  end

  // Clearing sweep and the size the frame store belongs to.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
      st_w       <= WB'(RST_W);
      st_h       <= HB'(RST_H);
    end else if (clr_active) begin
      if (clr_addr == FA'(FD - 1)) begin
        clr_active <= 1'b0;
        clr_addr   <= '0;
      end else begin
        clr_addr <= clr_addr + FA'(1);
      end
    end else if (need_clear && !s1_valid) begin
      clr_active <= 1'b1;
      st_w       <= sat_w;
      st_h       <= sat_h;
    end
  end

  // Frame store: cleared by the sweep, read at acceptance, written back as the result leaves.
  always_ff @(posedge clk) begin
    if (clr_active) begin
      fmem[clr_addr] <= '0;
    end else if (s1_valid && advance && !s1.bypass) begin
      fmem[s1.fa] <= centre;
    end
    if (accept && emit) begin
      fs_rd <= fmem[fa];
    end
  end

  // Result stage occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= emit;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      s1 <= s1_next;
    end
  end

  // Stencil arithmetic for each channel.
  always_comb begin
    centre = s1.x0 ? s1.first : cen_reg;
    ncnt   = 3'(s1.has_left) + 3'(s1.has_right) + 3'(s1.has_above) + 3'(s1.has_below);
    filt   = '0;
    sum    = '0;
    half   = '0;
    prev   = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      sum = (s1.has_left  ? 10'(left_reg[k*CH_W +: CH_W]) : 10'd0)
          + (s1.has_right ? 10'(rd_right[k*CH_W +: CH_W]) : 10'd0)
          + (s1.has_above ? 10'(rd_above[k*CH_W +: CH_W]) : 10'd0)
          + (s1.has_below ? 10'(s1.below[k*CH_W +: CH_W]) : 10'd0);
      half = (ncnt == 3'd2) ? sum[8:0] : sum[9:1];
      prev = fs_rd[k*CH_W +: CH_W];
      if (half < 9'(prev)) begin
        filt[k*CH_W +: CH_W] = '0;
      end else if ((half - 9'(prev)) > 9'd255) begin
        filt[k*CH_W +: CH_W] = 8'hFF;
      end else begin
        filt[k*CH_W +: CH_W] = CH_W'(half - 9'(prev));
      end
    end
    res = s1.bypass ? centre : filt;
  end

  // Output register and the sliding center/left window.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      pixel_out <= res;
      frame_end <= s1.f_end;
      cen_reg   <= rd_right;
      left_reg  <= centre;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/wrs_checker.sv */
`default_nettype none
`include "water_ripple_stencil_top_defines.svh"

module wrs_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [wrs_pkg::PIX_W-1:0] pixel_out,
  input logic                      frame_end
);

  // A stalled result word stays in place.
  `WRS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(pixel_out) && $stable(frame_end))

  // Nothing leaves right after reset.
  `WRS_ASSERT_IMPLY(a_out_idle_after_rst, clk, rst, $past(rst), !out_valid)

  // The frame store sweep blocks input right after reset.
  `WRS_ASSERT_IMPLY(a_in_blocked_after_rst, clk, rst, $past(rst), in_stall)

endmodule

bind water_ripple_stencil_top wrs_checker u_wrs_checker (.*);

`default_nettype wire
